// File: sv/bertlv_pkg.sv
package bertlv_pkg;

  localparam logic [4:0] ID_TAG_MASK = 5'h1f;  // low tag bits all set: high-form tag follows
  localparam logic [7:0] LEN_INDEF   = 8'h80;  // indefinite length, rejected

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_TAG     = 4'b0010,
    PH_LEN1    = 4'b0100,
    PH_LENMORE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_tlv;
    logic [15:0] bytes_left;
  } in_word_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] tag_accum;
    logic [31:0] length_accum;
    logic [6:0]  length_bytes_due;
    logic        constructed_bit;
    logic [15:0] header_count;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    logic        constructed;
    logic [31:0] tag_number;
    logic [15:0] value_length;
    logic [15:0] header_bytes;
    logic        parse_error;
  } result_t;

endpackage

// File: sv/bertlv_core.sv
module bertlv_core (
  input  bertlv_pkg::in_word_t     item,
  input  bertlv_pkg::parse_state_t st,
  output bertlv_pkg::parse_state_t st_nxt,
  output bertlv_pkg::result_t      res
);
  import bertlv_pkg::*;

  logic        last;
  logic [15:0] rem;
  logic        do_err;
  logic        do_done;
  logic [6:0]  due_dec;
  logic [7:0]  b;

  assign b       = item.data_byte;
  assign last    = (item.bytes_left <= 16'd1);
  assign rem     = last ? 16'd0 : item.bytes_left - 16'd1;
  assign due_dec = st.length_bytes_due - 7'd1;

  always_comb begin
    st_nxt  = st;
    do_err  = 1'b0;
    do_done = 1'b0;
    if (item.start_of_tlv) begin
      // new start drops any parse in flight
      st_nxt.tag_accum        = '0;
      st_nxt.length_accum     = '0;
      st_nxt.length_bytes_due = '0;
      st_nxt.constructed_bit  = b[5];
      st_nxt.header_count     = 16'd1;
      if (item.bytes_left < 16'd2) begin
        st_nxt.constructed_bit = 1'b0;
        do_err = 1'b1;
      end else if (b[4:0] == ID_TAG_MASK) begin
        st_nxt.phase = PH_TAG;
      end else begin
        st_nxt.tag_accum = {27'd0, b[4:0]};
        st_nxt.phase     = PH_LEN1;
      end
    end else begin
      case (st.phase)
        PH_TAG: begin
          st_nxt.header_count = st.header_count + 16'd1;
          st_nxt.tag_accum    = {st.tag_accum[24:0], b[6:0]};
          if (last) begin
            do_err = 1'b1;
          end else if (!b[7]) begin
            st_nxt.phase = PH_LEN1;
          end
        end
        PH_LEN1: begin
          st_nxt.header_count = st.header_count + 16'd1;
          if (b == LEN_INDEF) begin
            do_err = 1'b1;
          end else if (b[7]) begin
            st_nxt.length_bytes_due = b[6:0];
            st_nxt.length_accum     = '0;
            if (last) begin
              do_err = 1'b1;
            end else begin
              st_nxt.phase = PH_LENMORE;
            end
          end else begin
            st_nxt.length_accum = {24'd0, b};
            do_done = 1'b1;
          end
        end
        PH_LENMORE: begin
          st_nxt.header_count     = st.header_count + 16'd1;
          st_nxt.length_accum     = {st.length_accum[23:0], b};
          st_nxt.length_bytes_due = due_dec;
          if (due_dec == 7'd0) begin
            do_done = 1'b1;
          end else if (last) begin
            do_err = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (do_err || do_done) begin
      st_nxt.phase = PH_IDLE;
    end
  end

  // result word; errors zero everything but valid, parse_error and the byte count
  always_comb begin
    res              = '0;
    res.valid        = do_err || do_done;
    res.header_bytes = st_nxt.header_count;
    res.parse_error  = do_err;
    if (do_done) begin
      res.constructed  = st_nxt.constructed_bit;
      res.tag_number   = st_nxt.tag_accum;
      res.value_length = (st_nxt.length_accum > {16'd0, rem}) ? rem
                                                              : st_nxt.length_accum[15:0];
    end
  end

endmodule

// File: sv/ber_tlv_header_parser.sv
// BER TLV header parser.
// Input channel: one buffer byte per word (in_data_byte), with in_start_of_tlv
// marking the identifier byte of a new header and in_bytes_left giving the
// bytes left in the buffer counting this one. Bytes that arrive while no
// parse is open and without a start mark are dropped.
// Output channel: one word per header, when it completes or fails:
// constructed bit, tag number (low 32 bits), value length clamped to the
// bytes after the header, header byte count, and parse_error. On error all
// fields but header_bytes and parse_error are zero. Value bytes are not consumed here.
// Timing: a byte is registered at acceptance, decoded combinationally from
// the input register, and its result (if any) is loaded into the output
// register when the decode stage advances, which raises out_valid.
// One byte per cycle sustained while out_ready holds no word back; the single
// decode stage between input and output registers sets that rate.
// Stall: while out_valid is held off by out_ready, the decode stage waits;
// one more byte can be taken into the input register, then in_ready stays
// low, whether or not that byte makes a result, until the word is taken.
// Reset (rst_n low, synchronous): both registers empty, parser idle.
module ber_tlv_header_parser #(
  parameter int BUFFER_LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_tlv,
  input  logic [15:0] in_bytes_left,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_constructed,
  output logic [31:0] out_tag_number,
  output logic [15:0] out_value_length,
  output logic [15:0] out_header_bytes,
  output logic        out_parse_error
);
  import bertlv_pkg::*;

  // bytes_left is seen through a buffer-size mask
  localparam int          BL_W    = (BUFFER_LEN_BITS < 16) ? BUFFER_LEN_BITS : 16;
  localparam logic [15:0] BL_MASK = 16'((32'd1 << BL_W) - 32'd1);

  logic         in_valid_r;
  in_word_t     in_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  result_t      res;
  logic         out_valid_r;
  result_t      out_r;
  logic         adv;

  // decode stage moves when the output register is free or draining
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r.data_byte    <= in_data_byte;
      in_r.start_of_tlv <= in_start_of_tlv;
      in_r.bytes_left   <= in_bytes_left & BL_MASK;
    end
  end

  bertlv_core u_core (
    .item   (in_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= PH_IDLE;
      state_r.tag_accum        <= '0;
      state_r.length_accum     <= '0;
      state_r.length_bytes_due <= '0;
      state_r.constructed_bit  <= 1'b0;
      state_r.header_count     <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_constructed  = out_r.constructed;
  assign out_tag_number   = out_r.tag_number;
  assign out_value_length = out_r.value_length;
  assign out_header_bytes = out_r.header_bytes;
  assign out_parse_error  = out_r.parse_error;

  // failed headers carry no tag, length or constructed bit
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.parse_error |->
      (out_r.tag_number == 32'd0) && (out_r.value_length == 16'd0) && !out_r.constructed)
    else $error("error result with nonzero fields");

  // every emitted result closes the parse
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.valid |=> state_r.phase == PH_IDLE)
    else $error("parser not idle after result");

  // a byte held in the input stage is not overwritten while the stage is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_r))
    else $error("input stage lost a byte");

  // a result is only loaded when the output register is free or taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> !out_valid_r || out_ready)
    else $error("output register overrun");

endmodule

// File: tb/ber_tlv_header_checker.sv
module ber_tlv_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_tlv,
  input  logic [15:0] in_bytes_left,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_constructed,
  input  logic [31:0] out_tag_number,
  input  logic [15:0] out_value_length,
  input  logic [15:0] out_header_bytes,
  input  logic        out_parse_error,
  output int          fail_count,
  output int          pending,
  output int          bytes_taken,
  output int          headers_checked,
  output int          headers_failed
);
  import bertlv_pkg::*;

  typedef struct packed {
    logic        constructed;
    logic [31:0] tag_number;
    logic [15:0] value_length;
    logic [15:0] header_bytes;
    logic        parse_error;
  } hdr_result_t;

  hdr_result_t header_q[$];

  // decoder shadow state
  phase_t      ph;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic [6:0]  len_due;
  logic        cons_bit;
  logic [15:0] hdr_count;

  int mismatches;
  int n_bytes;
  int n_checked;
  int n_failed;

  function automatic void post_error();
    hdr_result_t r;
    r = '0;
    r.header_bytes = hdr_count;
    r.parse_error  = 1'b1;
    header_q.push_back(r);
    ph = PH_IDLE;
  endfunction

  function automatic void post_header(input logic [15:0] room);
    hdr_result_t r;
    r.constructed  = cons_bit;
    r.tag_number   = tag_acc;
    r.value_length = (len_acc > {16'd0, room}) ? room : len_acc[15:0];
    r.header_bytes = hdr_count;
    r.parse_error  = 1'b0;
    header_q.push_back(r);
    ph = PH_IDLE;
  endfunction

  // one buffer byte through the decoder
  function automatic void decode_byte(input logic [7:0] b, input logic st,
                                      input logic [15:0] bl);
    logic        last;
    logic [15:0] room;
    last = (bl <= 16'd1);
    room = last ? 16'd0 : bl - 16'd1;
    if (st) begin
      tag_acc   = '0;
      len_acc   = '0;
      len_due   = '0;
      cons_bit  = b[5];
      hdr_count = 16'd1;
      if (bl < 16'd2) begin
        cons_bit = 1'b0;
        post_error();
      end else if (b[4:0] == ID_TAG_MASK) begin
        ph = PH_TAG;
      end else begin
        tag_acc = {27'd0, b[4:0]};
        ph      = PH_LEN1;
      end
    end else begin
      case (ph)
        PH_TAG: begin
          hdr_count = hdr_count + 16'd1;
          tag_acc   = {tag_acc[24:0], b[6:0]};
          if (last) post_error();
          else if (!b[7]) ph = PH_LEN1;
        end
        PH_LEN1: begin
          hdr_count = hdr_count + 16'd1;
          if (b == LEN_INDEF) begin
            post_error();
          end else if (b[7]) begin
            len_due = b[6:0];
            len_acc = '0;
            if (last) post_error();
            else ph = PH_LENMORE;
          end else begin
            len_acc = {24'd0, b};
            post_header(room);
          end
        end
        PH_LENMORE: begin
          hdr_count = hdr_count + 16'd1;
          len_acc   = {len_acc[23:0], b};
          len_due   = len_due - 7'd1;
          if (len_due == 7'd0) post_header(room);
          else if (last) post_error();
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    hdr_result_t e;
    if (!rst_n) begin
      ph        = PH_IDLE;
      tag_acc   = '0;
      len_acc   = '0;
      len_due   = '0;
      cons_bit  = 1'b0;
      hdr_count = '0;
      header_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (header_q.size() == 0) begin
          $error("header word with nothing expected: tag %0h len %0h err %0b",
                 out_tag_number, out_value_length, out_parse_error);
          mismatches++;
        end else begin
          e = header_q.pop_front();
          check_field("constructed", {31'd0, e.constructed}, {31'd0, out_constructed});
          check_field("tag_number", e.tag_number, out_tag_number);
          check_field("value_length", {16'd0, e.value_length}, {16'd0, out_value_length});
          check_field("header_bytes", {16'd0, e.header_bytes}, {16'd0, out_header_bytes});
          check_field("parse_error", {31'd0, e.parse_error}, {31'd0, out_parse_error});
          n_checked++;
          if (e.parse_error) n_failed++;
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_start_of_tlv, in_bytes_left);
        n_bytes++;
      end
    end
    fail_count      <= mismatches;
    pending         <= header_q.size();
    bytes_taken     <= n_bytes;
    headers_checked <= n_checked;
    headers_failed  <= n_failed;
  end

endmodule

// File: tb/ber_tlv_header_parser_tb.sv
module ber_tlv_header_parser_tb;
  import bertlv_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // cycles with no word moving on either side before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  // bytes per idling phase, every byte taken on the input channel counted
  localparam int PHASE_BYTES = 312;
  // input register to output register, plus margin
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_start_of_tlv = 1'b0;
  logic [15:0] in_bytes_left = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_constructed;
  logic [31:0] out_tag_number;
  logic [15:0] out_value_length;
  logic [15:0] out_header_bytes;
  logic        out_parse_error;

  int fail_count;
  int pending;
  int bytes_taken;
  int headers_checked;
  int headers_failed;

  int send_gap_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;      // chance per cycle that the receiver drops ready
  int words_sent = 0;     // bytes taken on the input channel
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  ber_tlv_header_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_tlv  (in_start_of_tlv),
    .in_bytes_left    (in_bytes_left),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_constructed  (out_constructed),
    .out_tag_number   (out_tag_number),
    .out_value_length (out_value_length),
    .out_header_bytes (out_header_bytes),
    .out_parse_error  (out_parse_error)
  );

  ber_tlv_header_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_tlv  (in_start_of_tlv),
    .in_bytes_left    (in_bytes_left),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_constructed  (out_constructed),
    .out_tag_number   (out_tag_number),
    .out_value_length (out_value_length),
    .out_header_bytes (out_header_bytes),
    .out_parse_error  (out_parse_error),
    .fail_count       (fail_count),
    .pending          (pending),
    .bytes_taken      (bytes_taken),
    .headers_checked  (headers_checked),
    .headers_failed   (headers_failed)
  );

  // Receiver: ready re-rolled every cycle; stall_pct 0 keeps it high.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: counts cycles in which no word is taken on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d header words pending",
               quiet_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte onto the input channel. Called right at a clock edge: either
  // right after reset or in the step where the previous byte was taken.
  // Valid is only dropped when a gap is rolled, so back-to-back bytes keep
  // valid high with a single assignment per step.
  task automatic send_word(input logic [7:0] b, input logic st, input logic [15:0] bl);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_start_of_tlv <= st;
    in_bytes_left   <= bl;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // A header run: the first byte carries the start mark, bytes_left counts
  // down by one per byte. Trailing value bytes follow without a start mark;
  // the parser should ignore them. The run stops at the buffer's last byte.
  task automatic send_run(input byte_q_t hdr, input int unsigned bl0, input int fill);
    int unsigned left;
    left = bl0;
    foreach (hdr[i]) begin
      send_word(hdr[i], i == 0, left[15:0]);
      if (left <= 1) return;
      left--;
    end
    repeat (fill) begin
      send_word(8'($urandom), 1'b0, left[15:0]);
      if (left <= 1) return;
      left--;
    end
  endtask

  // Sender holds off until every expected header word has come out. The
  // first edge lets the checker count the byte taken in this step.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random but mostly well-formed header: identifier, optional high-form
  // tag groups, then a short, long or indefinite length.
  function automatic byte_q_t random_header();
    byte_q_t     hdr;
    logic [7:0]  id;
    logic [7:0]  b;
    int          ngrp;
    int          nlen;
    int          r;
    id = 8'($urandom);
    if ($urandom_range(2) == 0) id[4:0] = ID_TAG_MASK;  // lean on high-form tags
    hdr.push_back(id);
    if (id[4:0] == ID_TAG_MASK) begin
      // 5+ groups overflow the 32-bit tag
      ngrp = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      for (int g = 0; g < ngrp; g++) begin
        b    = 8'($urandom);
        b[7] = (g != ngrp - 1);
        hdr.push_back(b);
      end
    end
    r = $urandom_range(99);
    if (r < 46) begin
      hdr.push_back(8'($urandom_range(0, 127)));
    end else if (r == 99) begin
      nlen = 0;  // marker for the widest long form below
    end else if (r >= 94) begin
      hdr.push_back(LEN_INDEF);
    end
    if (r >= 46 && r < 94 || r == 99) begin
      if (r == 99) nlen = $urandom_range(9, 127);
      else if (r < 86) nlen = $urandom_range(1, 4);
      else nlen = $urandom_range(5, 8);  // length beyond 32 bits
      hdr.push_back(8'h80 | 8'(nlen));
      repeat (nlen) hdr.push_back(8'($urandom));
    end
    return hdr;
  endfunction

  // Buffer size for a run: mostly room to spare, some too short to hold the
  // header, some near the top of the 16-bit range.
  function automatic int unsigned pick_buffer(input int hdr_len);
    int r;
    r = $urandom_range(99);
    if (r < 55) return hdr_len + $urandom_range(0, 300);
    if (r < 75) return $urandom_range(1, hdr_len);
    if (r < 92) return $urandom_range(hdr_len, 65535);
    return 65535 - $urandom_range(0, 3);
  endfunction

  initial begin
    byte_q_t hdr;
    int      r;
    int      target;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed headers.
    send_run('{8'h02, 8'h03}, 10, 2);                 // short form, value bytes ignored
    send_run('{8'h30, 8'h7f}, 50, 0);                 // constructed, length clamped
    send_run('{8'ha1}, 1, 0);                         // start with one byte left: too short
    send_run('{8'hff, 8'h81, 8'h7f, 8'h00}, 65535, 0);  // high-form tag, all-ones id byte
    send_run('{8'h04, 8'h82, 8'hff, 8'hff}, 300, 0);  // long form, clamped
    send_run('{8'h30, LEN_INDEF}, 20, 0);             // indefinite length rejected
    send_run('{8'h1f, 8'h85}, 2, 0);                  // buffer ends inside tag
    send_run('{8'h04, 8'h82, 8'h01}, 3, 0);           // buffer ends inside long length
    send_run('{8'h1f, 8'h81}, 40, 0);                 // dropped by the restart below
    send_run('{8'h02, 8'h00}, 10, 0);                 // restart mid-parse, zero length
    send_run('{8'h05, 8'h7f}, 2, 0);                  // length byte is the last byte

    // Random part over four idling phases, a full drain before each change.
    for (int p = 0; p < 4; p++) begin
      drain_outputs();
      case (p)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 64; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 64; end
        default: begin send_gap_pct = 38; stall_pct = 38; end
      endcase
      target = words_sent + PHASE_BYTES;
      while (words_sent < target) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // stray byte: random mark and size
          send_word(8'($urandom), $urandom_range(3) == 0, 16'($urandom_range(1, 65535)));
        end else begin
          hdr = random_header();
          // broken run: cut short, the next start drops it
          if (r < 18 && hdr.size() > 1) hdr = hdr[0:$urandom_range(hdr.size() - 2)];
          send_run(hdr, pick_buffer(hdr.size()), $urandom_range(0, 3));
        end
      end
    end

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run fed %0d bytes and checked %0d header words, %0d of them parse errors,",
             bytes_taken, headers_checked, headers_failed);
    $display("across phases with no idling, sender gaps, receiver stalls and both.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bertlv_pkg.sv
sv/bertlv_core.sv
sv/ber_tlv_header_parser.sv
tb/ber_tlv_header_checker.sv
tb/ber_tlv_header_parser_tb.sv
